/* src/sidiv_pkg.sv */
`default_nettype none

package sidiv_pkg;

  // Controller phases
  typedef enum logic [1:0] {
    StIdle,
    StBusy
  } ctrl_state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;    // capture operand magnitudes and signs
    logic step;    // one restoring shift-and-subtract step
    logic finish;  // apply sign and special cases into the output register
  } dp_cmd_t;

endpackage

`default_nettype wire

/* src/sidiv_datapath.sv */
`default_nettype none

module sidiv_datapath
  import sidiv_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input  wire                   clk_i,
  input  dp_cmd_t               cmd_i,
  input  wire  [DATA_WIDTH-1:0] numerator_i,
  input  wire  [DATA_WIDTH-1:0] denominator_i,
  output logic [DATA_WIDTH-1:0] quotient_o,
  output logic                  zero_divisor_o,
  output logic                  overflowed_o
);

  localparam int W = DATA_WIDTH;

  logic [W-1:0] num_mag;
  logic [W-1:0] den_mag;

  // working registers: dividend shifts out at the top while quotient bits enter below
  logic [W-1:0] acc_q, acc_d;
  logic [W-1:0] rem_q, rem_d;
  logic [W-1:0] div_q, div_d;
  logic         neg_q, neg_d;
  logic         zero_q, zero_d;

  logic [W-1:0] res_q, res_d;
  logic         zdiv_q, zdiv_d;
  logic         ovf_q, ovf_d;

  logic [W:0]   rem_shift;
  logic         ge;

  assign num_mag = numerator_i[W-1] ? (~numerator_i + W'(1)) : numerator_i;
  assign den_mag = denominator_i[W-1] ? (~denominator_i + W'(1)) : denominator_i;

  assign rem_shift = {rem_q, acc_q[W-1]};
  assign ge        = rem_shift >= {1'b0, div_q};

  always_comb begin
    acc_d  = acc_q;
    rem_d  = rem_q;
    div_d  = div_q;
    neg_d  = neg_q;
    zero_d = zero_q;
    res_d  = res_q;
    zdiv_d = zdiv_q;
    ovf_d  = ovf_q;
    if (cmd_i.load) begin
      acc_d  = num_mag;
      rem_d  = '0;
      div_d  = den_mag;
      neg_d  = numerator_i[W-1] ^ denominator_i[W-1];
      zero_d = (denominator_i == '0);
    end
    if (cmd_i.step) begin
      rem_d = ge ? W'(rem_shift - {1'b0, div_q}) : rem_shift[W-1:0];
      acc_d = {acc_q[W-2:0], ge};
    end
    if (cmd_i.finish) begin
      zdiv_d = zero_q;
      ovf_d  = 1'b0;
      if (zero_q) begin
        res_d = '0;
      end else if (neg_q) begin
        res_d = ~acc_q + W'(1);
      end else if (acc_q[W-1]) begin
        // most negative over minus one: saturate
        res_d = {1'b0, {(W-1){1'b1}}};
        ovf_d = 1'b1;
      end else begin
        res_d = acc_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    rem_q  <= rem_d;
    div_q  <= div_d;
    neg_q  <= neg_d;
    zero_q <= zero_d;
    res_q  <= res_d;
    zdiv_q <= zdiv_d;
    ovf_q  <= ovf_d;
  end

  assign quotient_o     = res_q;
  assign zero_divisor_o = zdiv_q;
  assign overflowed_o   = ovf_q;

endmodule

`default_nettype wire

/* src/sidiv_ctrl.sv */
`default_nettype none

module sidiv_ctrl
  import sidiv_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input  wire     clk_i,
  input  wire     rst_ni,
  input  wire     in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  wire     out_ready_i,
  output dp_cmd_t cmd_o
);

  localparam int CNT_W = $clog2(DATA_WIDTH + 1);
  localparam logic [CNT_W-1:0] STEPS = CNT_W'(DATA_WIDTH);

  ctrl_state_e      state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    // drop the held result once taken
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = StBusy;
        end
      end
      StBusy: begin
        if (cnt_q != STEPS) begin
          cmd_o.step = 1'b1;
          cnt_d      = cnt_q + CNT_W'(1);
        end else if (!out_valid_q || out_ready_i) begin
          // hold here until the output register is free
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

/* src/signed_integer_divider_unit.sv */
// Channel  Direction  Payload
// s_axis   in         tdata: numerator, denominator
// m_axis   out        tdata: quotient; tuser: zero_divisor, overflowed
//
// Each request loads the operand magnitudes, runs DATA_WIDTH restoring steps
// through the single subtractor, and then applies sign and special cases into
// the output register.
// A new request is taken as soon as the previous one is in the output register.
// Reset clears the controller and output valid; a stalled output holds the
// finished result and the next one waits in the datapath.
`default_nettype none

module signed_integer_divider_unit
  import sidiv_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        s_axis_tvalid,
  output logic                       s_axis_tready,
  // numerator, denominator (lowest bits first), zero padded to bytes
  input  wire  [((2*DATA_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  wire                        m_axis_tready,
  // quotient, zero padded to bytes
  output logic [((DATA_WIDTH+7)/8)*8-1:0]   m_axis_tdata,
  // zero_divisor, overflowed (lowest bit first)
  output logic [1:0]                 m_axis_tuser
);

  localparam int OUT_TDATA_W = ((DATA_WIDTH + 7) / 8) * 8;

  dp_cmd_t               cmd;
  logic [DATA_WIDTH-1:0] quotient;
  logic                  zero_divisor;
  logic                  overflowed;

  sidiv_ctrl #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .cmd_o      (cmd)
  );

  sidiv_datapath #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .cmd_i         (cmd),
    .numerator_i   (s_axis_tdata[DATA_WIDTH-1:0]),
    .denominator_i (s_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH]),
    .quotient_o    (quotient),
    .zero_divisor_o(zero_divisor),
    .overflowed_o  (overflowed)
  );

  assign m_axis_tdata = OUT_TDATA_W'(quotient);
  assign m_axis_tuser = {overflowed, zero_divisor};

endmodule

`default_nettype wire

/* test/testbench.sv */
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int W = 32;
  localparam int IN_BITS = ((2*W+7)/8)*8;
  localparam int OUT_BITS = ((W+7)/8)*8;
  localparam logic [W-1:0] MOST_NEG = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] MOST_POS = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MINUS_ONE = '1;
  localparam int NUM_RANDOM = 480;
  localparam int SETTLE_CYCLES = 3*(W+2);
  localparam int HOLD_OFF_AT = 120;
  localparam int HOLD_OFF_CYCLES = 400;

  typedef struct packed {
    logic [W-1:0] quotient;
    logic         zero_divisor;
    logic         overflowed;
  } quotient_t;

  typedef struct packed {
    logic [W-1:0] numerator;
    logic [W-1:0] denominator;
    logic         known;   // result typed in below, else predicted
    quotient_t    result;
  } div_case_t;

  localparam int NUM_ROWS = 25;

  div_case_t division_rows [NUM_ROWS] = '{
    '{32'd0,       32'd5,        1'b1, '{32'd0,         1'b0, 1'b0}},
    '{32'd12345,   32'd0,        1'b1, '{32'd0,         1'b1, 1'b0}},
    '{MOST_NEG,    32'd0,        1'b1, '{32'd0,         1'b1, 1'b0}},
    '{MOST_POS,    32'd0,        1'b1, '{32'd0,         1'b1, 1'b0}},
    '{MINUS_ONE,   32'd0,        1'b1, '{32'd0,         1'b1, 1'b0}},
    '{32'd0,       32'd0,        1'b1, '{32'd0,         1'b1, 1'b0}},
    '{MOST_NEG,    MINUS_ONE,    1'b1, '{MOST_POS,      1'b0, 1'b1}},
    '{MOST_NEG,    32'd1,        1'b1, '{MOST_NEG,      1'b0, 1'b0}},
    '{MOST_POS,    32'd1,        1'b1, '{MOST_POS,      1'b0, 1'b0}},
    '{MOST_POS,    MINUS_ONE,    1'b1, '{32'h8000_0001, 1'b0, 1'b0}},
    '{MOST_POS,    MOST_POS,     1'b1, '{32'd1,         1'b0, 1'b0}},
    '{MOST_NEG,    MOST_NEG,     1'b1, '{32'd1,         1'b0, 1'b0}},
    '{32'd1,       MOST_NEG,     1'b1, '{32'd0,         1'b0, 1'b0}},
    '{MINUS_ONE,   MINUS_ONE,    1'b1, '{32'd1,         1'b0, 1'b0}},
    '{32'd100,          32'd7,          1'b0, '0},
    '{32'hFFFF_FFF9,    32'd2,          1'b0, '0},
    '{32'd7,            32'hFFFF_FFFE,  1'b0, '0},
    '{32'hFFFF_FFF9,    32'hFFFF_FFFE,  1'b0, '0},
    '{MOST_NEG,         32'd2,          1'b0, '0},
    '{MOST_POS,         MOST_NEG,       1'b0, '0},
    '{MOST_NEG,         MOST_POS,       1'b0, '0},
    '{MOST_NEG,         32'hFFFF_FFFE,  1'b0, '0},
    '{32'hAAAA_AAAA,    32'h5555_5555,  1'b0, '0},
    '{32'h5555_5555,    32'd3,          1'b0, '0},
    '{32'h0000_FFFF,    32'hFFFF_0000,  1'b0, '0}
  };

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [IN_BITS-1:0]  s_axis_tdata = '0;   // numerator, denominator
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OUT_BITS-1:0] m_axis_tdata;        // quotient
  logic [1:0]          m_axis_tuser;        // zero_divisor, overflowed

  quotient_t pending_quotients [$];
  int        mismatch_count = 0;

  signed_integer_divider_unit #(
    .DATA_WIDTH(W)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  function automatic quotient_t divide_truncating(logic [W-1:0] num, logic [W-1:0] den);
    logic         num_neg;
    logic         den_neg;
    logic [W-1:0] num_mag;
    logic [W-1:0] den_mag;
    logic [W-1:0] mag_q;
    quotient_t    r;
    num_neg = num[W-1];
    den_neg = den[W-1];
    // the most negative value maps onto its own magnitude as unsigned
    num_mag = num_neg ? -num : num;
    den_mag = den_neg ? -den : den;
    r = '0;
    if (den_mag == '0) begin
      r.zero_divisor = 1'b1;
    end else begin
      mag_q = num_mag / den_mag;
      if (num_neg != den_neg) begin
        r.quotient = -mag_q;
      end else if (mag_q > MOST_POS) begin
        r.quotient = MOST_POS;
        r.overflowed = 1'b1;
      end else begin
        r.quotient = mag_q;
      end
    end
    return r;
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic draw_operands(output logic [W-1:0] num, output logic [W-1:0] den);
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        num = $urandom;
        den = $urandom;
      end
      3: begin
        num = $urandom;
        den = $urandom_range(1, 15);
        if ($urandom_range(0, 1)) den = -den;
      end
      4: begin
        num = $urandom >> $urandom_range(0, W-1);
        den = $urandom >> $urandom_range(0, W-1);
        if ($urandom_range(0, 1)) num = -num;
        if ($urandom_range(0, 1)) den = -den;
      end
      5: begin
        num = $urandom;
        den = '0;
      end
      6: begin
        num = MOST_NEG;
        den = $urandom_range(0, 1) ? MINUS_ONE : $urandom;
      end
      7: begin
        num = $urandom;
        den = 1;
        den = den << $urandom_range(0, W-1);
        if ($urandom_range(0, 1)) den = -den;
      end
      default: begin
        // divisor of at most 16 bits against a dividend of random width
        num = $urandom >> $urandom_range(0, W-1);
        den = $urandom >> $urandom_range(16, W-1);
        if ($urandom_range(0, 1)) num = -num;
        if ($urandom_range(0, 1)) den = -den;
      end
    endcase
  endtask

  task automatic send_division(input int idx, input logic [W-1:0] num,
                               input logic [W-1:0] den, input logic known,
                               input quotient_t typed);
    int gap;
    gap = (idx >= 200 && idx < 260) ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {den, num};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_quotients.push_back(known ? typed : divide_truncating(num, den));
  endtask

  initial begin
    logic [W-1:0] num;
    logic [W-1:0] den;
    int           idx;
    idx = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (division_rows[i]) begin
      send_division(idx, division_rows[i].numerator, division_rows[i].denominator,
                    division_rows[i].known, division_rows[i].result);
      idx++;
    end
    repeat (NUM_RANDOM) begin
      draw_operands(num, den);
      send_division(idx, num, den, 1'b0, '0);
      idx++;
    end
    s_axis_tvalid <= 1'b0;
    while (pending_quotients.size() != 0) @(posedge clk_i);
    // catch any stray result after the last expected one
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("** signed_integer_divider_unit: PASSED **");
    end else begin
      $display("** signed_integer_divider_unit: FAILED **");
    end
    $finish;
  end

  initial begin
    int        stall;
    int        taken;
    quotient_t seen;
    quotient_t want;
    taken = 0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      // hold off once long enough to back the block up into its input
      if (taken == HOLD_OFF_AT) begin
        stall = HOLD_OFF_CYCLES;
      end else if (taken >= 300 && taken < 360) begin
        stall = 0;
      end else begin
        stall = $urandom_range(0, 4);
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      taken++;
      seen = '{m_axis_tdata[W-1:0], m_axis_tuser[0], m_axis_tuser[1]};
      if (pending_quotients.size() == 0) begin
        flag_mismatch($sformatf("result with no request pending: quotient %h", seen.quotient));
      end else begin
        want = pending_quotients.pop_front();
        if (seen.quotient !== want.quotient) begin
          flag_mismatch($sformatf("result %0d quotient %h, want %h",
                                  taken, seen.quotient, want.quotient));
        end
        if (seen.zero_divisor !== want.zero_divisor) begin
          flag_mismatch($sformatf("result %0d zero_divisor %b, want %b",
                                  taken, seen.zero_divisor, want.zero_divisor));
        end
        if (seen.overflowed !== want.overflowed) begin
          flag_mismatch($sformatf("result %0d overflowed %b, want %b",
                                  taken, seen.overflowed, want.overflowed));
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("** signed_integer_divider_unit: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire
